>>> src/fas_pkg.sv
package fas_pkg;

  // Fixed field widths
  localparam int TIME_W     = 32;
  localparam int SPEED_W    = 16;
  localparam int COUNT_W    = 5;
  localparam int INDEX_W    = 8;
  localparam int OPCODE_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED       = 2'd2;

  // Configuration reset values
  localparam logic [COUNT_W-1:0] FRAME_TOTAL_RST = 5'd1;
  localparam logic [SPEED_W-1:0] SPEED_RST       = 16'h0100;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK       = 3'd0,
    OP_START      = 3'd1,
    OP_PAUSE      = 3'd2,
    OP_RESUME     = 3'd3,
    OP_RESET      = 3'd4,
    OP_SEEK_TIME  = 3'd5,
    OP_SEEK_FRAME = 3'd6,
    OP_LOAD       = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_PAUSE = 2'd2,
    MODE_DONE  = 2'd3
  } run_mode_t;

endpackage

>>> src/fas_ram.sv
module fas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; rdata holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/frame_animation_sequencer_core.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// config   | cfg_we               | cfg_index, cfg_data
// in       | in_valid / in_ready  | opcode, now_ms, seek_time_ms, slot_index,
//          |                      | frame_duration_ms
// out      | out_valid / out_ready| frame_moved, shown_frame, run_state,
//          |                      | elapsed_in_frame_ms
//
// One item at a time. Start, pause, resume, reset, seek frame and load, and a tick
// outside run mode, go from decode straight to the result; a running tick also steps
// through timer delta, sum, 32x16 multiply, saturate and compare against the frame
// duration (adds and compares share one adder/subtractor). Seek time reads one table
// entry per cycle from the first to the one holding the seek time or the last frame.
// in_ready is high only while the sequencer is idle and returns the cycle after the
// result is registered; a result waiting on out_ready holds back the next result, not
// the next accept. rst is synchronous and clears control, configuration and play
// state; the duration table is not cleared.
module frame_animation_sequencer_core #(
  parameter int MAX_FRAMES = 16,
  localparam int POS_W = $clog2(MAX_FRAMES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fas_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fas_pkg::OPCODE_W-1:0]        opcode,
  input  logic [fas_pkg::TIME_W-1:0]          now_ms,
  input  logic [fas_pkg::TIME_W-1:0]          seek_time_ms,
  input  logic [fas_pkg::INDEX_W-1:0]         slot_index,
  input  logic [fas_pkg::TIME_W-1:0]          frame_duration_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                frame_moved,
  output logic [POS_W-1:0]                    shown_frame,
  output logic [1:0]                          run_state,
  output logic [fas_pkg::TIME_W-1:0]          elapsed_in_frame_ms
);

  localparam int TW      = fas_pkg::TIME_W;
  localparam int SW      = fas_pkg::SPEED_W;
  localparam int CMP_W   = fas_pkg::INDEX_W + 1;
  localparam int ALU_W   = TW + POS_W + 1;
  localparam int PROD_W  = TW + SW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_T_SUM,
    S_T_MUL,
    S_T_SAT,
    S_T_CMP,
    S_SEEK,
    S_DONE
  } state_t;

  state_t state;
  state_t decode_next;

  // Configuration
  logic [fas_pkg::COUNT_W-1:0] frame_total;
  logic                        loop_enable;
  logic [SW-1:0]               speed;

  // Play state
  fas_pkg::run_mode_t mode;
  logic [POS_W-1:0]   pos;
  logic [TW-1:0]      anchor;
  logic [TW-1:0]      elapsed;
  logic               changed;

  // Latched item
  fas_pkg::opcode_t            op_q;
  logic [TW-1:0]               now_q;
  logic [TW-1:0]               seek_q;
  logic [fas_pkg::INDEX_W-1:0] fidx_q;
  logic [TW-1:0]               fdur_q;

  // Working registers
  logic [TW-1:0]     acc;
  logic [PROD_W-1:0] prod;
  logic [TW-1:0]     scaled;
  logic [POS_W-1:0]  walk_idx;
  logic [ALU_W-1:0]  start;

  // Speed sign and magnitude
  logic          speed_neg;
  logic [SW-1:0] speed_mag;
  assign speed_neg = speed[SW-1];
  assign speed_mag = speed_neg ? (~speed + SW'(1)) : speed;

  // Last frame in use: count clamped to 1..MAX_FRAMES, minus one
  logic [CMP_W-1:0] fc_ext;
  logic [CMP_W-1:0] max_ext;
  logic [CMP_W-1:0] last_ext;
  logic [POS_W-1:0] last;
  assign fc_ext  = CMP_W'(frame_total);
  assign max_ext = CMP_W'(MAX_FRAMES);
  always_comb begin
    if (frame_total == '0) begin
      last_ext = '0;
    end else if (fc_ext > max_ext) begin
      last_ext = max_ext - CMP_W'(1);
    end else begin
      last_ext = fc_ext - CMP_W'(1);
    end
  end
  assign last = last_ext[POS_W-1:0];

  // Seek frame target and load slot check
  logic [CMP_W-1:0] idx_ext;
  logic [POS_W-1:0] seek_frame_pos;
  logic             load_ok;
  assign idx_ext        = CMP_W'(fidx_q);
  assign seek_frame_pos = (idx_ext > CMP_W'(last)) ? last : fidx_q[POS_W-1:0];
  assign load_ok        = idx_ext < max_ext;

  // Where decode goes: tick while running and seek time need more cycles
  assign decode_next = (op_q == fas_pkg::OP_TICK && mode == fas_pkg::MODE_RUN) ? S_T_SUM :
                       (op_q == fas_pkg::OP_SEEK_TIME) ? S_SEEK : S_DONE;

  // Duration table
  logic             ram_we;
  logic             ram_re;
  logic [POS_W-1:0] ram_raddr;
  logic [TW-1:0]    ram_rdata;

  assign ram_we = (state == S_DECODE) && (op_q == fas_pkg::OP_LOAD) && load_ok;

  fas_ram #(
    .WIDTH(TW),
    .DEPTH(MAX_FRAMES)
  ) u_dur_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fidx_q[POS_W-1:0]),
    .wdata(fdur_q),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared adder/subtractor; top bit is the borrow on subtract
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic             alu_sub;
  logic [ALU_W:0]   alu_res;
  logic             alu_borrow;

  always_comb begin
    case (state)
      S_DECODE: begin
        alu_a   = ALU_W'(now_q);
        alu_b   = ALU_W'(anchor);
        alu_sub = 1'b1;
      end
      S_T_SUM: begin
        alu_a   = ALU_W'(elapsed);
        alu_b   = ALU_W'(acc);
        alu_sub = 1'b0;
      end
      S_T_CMP: begin
        alu_a   = ALU_W'(scaled);
        alu_b   = ALU_W'(ram_rdata);
        alu_sub = 1'b1;
      end
      S_SEEK: begin
        alu_a   = start;
        alu_b   = ALU_W'(ram_rdata);
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_borrow = alu_res[ALU_W];

  // Seek walk decisions
  logic          seek_hit;
  logic          seek_last;
  logic [TW-1:0] seek_off;
  assign seek_hit  = ALU_W'(seek_q) < alu_res[ALU_W-1:0];
  assign seek_last = walk_idx == last;
  assign seek_off  = seek_q - start[TW-1:0];

  // Duration read address
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_DECODE: begin
        if (op_q == fas_pkg::OP_TICK && mode == fas_pkg::MODE_RUN) begin
          ram_re    = 1'b1;
          ram_raddr = pos;
        end else if (op_q == fas_pkg::OP_SEEK_TIME) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      S_SEEK: begin
        if (!seek_hit && !seek_last) begin
          ram_re    = 1'b1;
          ram_raddr = walk_idx + POS_W'(1);
        end
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = '0;
      end
    endcase
  end

  // Scale saturation at 32 bits
  logic [TW-1:0] sat_val;
  assign sat_val = (|prod[PROD_W-1:TW+8]) ? '1 : prod[TW+7:8];

  assign in_ready = (state == S_IDLE);

  // Sequencer, play state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      frame_total <= fas_pkg::FRAME_TOTAL_RST;
      loop_enable <= 1'b0;
      speed       <= fas_pkg::SPEED_RST;
      mode        <= fas_pkg::MODE_INIT;
      pos         <= '0;
      anchor      <= '0;
      elapsed     <= '0;
      changed     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fas_pkg::REG_FRAME_TOTAL: frame_total <= cfg_data[fas_pkg::COUNT_W-1:0];
          fas_pkg::REG_LOOP_ENABLE: loop_enable <= cfg_data[0];
          fas_pkg::REG_SPEED:       speed       <= cfg_data[SW-1:0];
          default: ;
        endcase
      end

      // Result valid: set when a result is registered, cleared once taken
      if (state == S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= fas_pkg::opcode_t'(opcode);
            now_q  <= now_ms;
            seek_q <= seek_time_ms;
            fidx_q <= slot_index;
            fdur_q <= frame_duration_ms;
            state  <= S_DECODE;
          end
        end

        S_DECODE: begin
          changed <= 1'b0;
          state   <= decode_next;
          case (op_q)
            fas_pkg::OP_TICK: begin
              if (mode == fas_pkg::MODE_RUN) begin
                acc    <= alu_res[TW-1:0];
                anchor <= now_q;
              end
            end
            fas_pkg::OP_START: begin
              if (mode == fas_pkg::MODE_INIT) begin
                anchor  <= now_q;
                elapsed <= '0;
                mode    <= fas_pkg::MODE_RUN;
              end
            end
            fas_pkg::OP_PAUSE: begin
              if (mode == fas_pkg::MODE_RUN) begin
                mode <= fas_pkg::MODE_PAUSE;
              end
            end
            fas_pkg::OP_RESUME: begin
              if (mode == fas_pkg::MODE_PAUSE) begin
                mode   <= fas_pkg::MODE_RUN;
                anchor <= now_q;
              end
            end
            fas_pkg::OP_RESET: begin
              pos     <= speed_neg ? last : '0;
              elapsed <= '0;
              mode    <= fas_pkg::MODE_INIT;
            end
            fas_pkg::OP_SEEK_TIME: begin
              walk_idx <= '0;
              start    <= '0;
            end
            fas_pkg::OP_SEEK_FRAME: begin
              pos     <= seek_frame_pos;
              elapsed <= '0;
            end
            default: ;
          endcase
        end

        // Time spent in frame plus timer delta, modulo 2^32
        S_T_SUM: begin
          acc   <= alu_res[TW-1:0];
          state <= S_T_MUL;
        end

        S_T_MUL: begin
          prod  <= PROD_W'(acc) * PROD_W'(speed_mag);
          state <= S_T_SAT;
        end

        S_T_SAT: begin
          scaled <= sat_val;
          state  <= S_T_CMP;
        end

        // Frame steps, wraps or ends play when scaled time reaches the duration
        S_T_CMP: begin
          state <= S_DONE;
          if (alu_borrow) begin
            elapsed <= scaled;
          end else begin
            elapsed <= alu_res[TW-1:0];
            if (speed_neg) begin
              if (pos != '0) begin
                pos     <= pos - POS_W'(1);
                changed <= 1'b1;
              end else if (loop_enable) begin
                pos     <= last;
                changed <= 1'b1;
              end else begin
                mode <= fas_pkg::MODE_DONE;
              end
            end else begin
              if (pos < last) begin
                pos     <= pos + POS_W'(1);
                changed <= 1'b1;
              end else if (loop_enable) begin
                pos     <= '0;
                changed <= 1'b1;
              end else begin
                mode <= fas_pkg::MODE_DONE;
              end
            end
          end
        end

        // Walk the table, one entry per cycle
        S_SEEK: begin
          if (seek_hit) begin
            pos     <= walk_idx;
            elapsed <= seek_off;
            state   <= S_DONE;
          end else if (seek_last) begin
            pos     <= last;
            elapsed <= ram_rdata;
            state   <= S_DONE;
          end else begin
            start    <= alu_res[ALU_W-1:0];
            walk_idx <= walk_idx + POS_W'(1);
          end
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            frame_moved         <= changed;
            shown_frame         <= pos;
            run_state           <= mode;
            elapsed_in_frame_ms <= elapsed;
            state               <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/fas_checker.sv
module fas_checker #(
  parameter int MAX_FRAMES = 16,
  localparam int POS_W = $clog2(MAX_FRAMES)
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       frame_moved,
  input logic [POS_W-1:0]           shown_frame,
  input logic [1:0]                 run_state,
  input logic [fas_pkg::TIME_W-1:0] elapsed_in_frame_ms
);

  // Reset leaves no result pending and the input open
  a_reset_clean: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("out_valid or in_ready wrong after reset");

  // Only one item in flight: accept closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while one is in work");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(frame_moved) && $stable(shown_frame) &&
       $stable(run_state) && $stable(elapsed_in_frame_ms)))
    else $error("result changed while stalled");

  // A frame change only comes from a tick that leaves playback running
  a_change_running: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_moved) |-> (run_state == fas_pkg::MODE_RUN))
    else $error("frame change reported outside running state");

endmodule

bind frame_animation_sequencer_core fas_checker #(.MAX_FRAMES(MAX_FRAMES)) u_fas_checker (.*);
